// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/usch_pkg.sv -----
// Package for the urgency-weighted request scheduler: sizes, codes, beat types.
// No dependencies; used by every module of the block except usch_ram.
package usch_pkg;

	localparam int QUEUE_SLOTS = 64;
	localparam int VM_SLOTS    = 16;

	localparam int QIW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int QCW = $clog2(QUEUE_SLOTS + 1);
	localparam int VIW = (VM_SLOTS > 1) ? $clog2(VM_SLOTS) : 1;
	localparam int VCW = $clog2(VM_SLOTS + 1);

	// depth never exceeds the queue size
	localparam int DW  = QCW;
	// base*weight fits 9 bits, (10 + depth) fits DW+1 bits
	localparam int BWW = 9;
	localparam int PW  = BWW + DW + 1;
	localparam int EW  = 33;
	localparam int MW  = PW + EW;

	localparam int SCORE_W = 48;
	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam int QC_W = 7;

	localparam logic [1:0] REQ_ENQ = 2'd0;
	localparam logic [1:0] REQ_DEQ = 2'd1;
	localparam logic [1:0] REQ_CPL = 2'd2;
	localparam logic [1:0] REQ_NOP = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] PRIO_HIGH = 2'd2;
	localparam logic [1:0] PRIO_MID  = 2'd1;

	localparam logic [6:0] WEIGHT_MAX = 7'd100;
	localparam logic [6:0] WEIGHT_DEF = 7'd50;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic [31:0] vm_id;
		logic [31:0] req_tag;
		logic [1:0]  priority_req;
		logic [6:0]  weight;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        out_vm_id;
		logic [31:0]        out_req_tag;
		logic [1:0]         out_priority;
		logic [6:0]         out_weight;
		logic [SCORE_W-1:0] out_score;
		logic [QC_W-1:0]    queue_count;
		logic [31:0]        switch_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] vm;
		logic [31:0] request;
		logic [1:0]  prio;
		logic [6:0]  weight;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic mv_rd;
		logic mv_wr;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_scan;
		logic scan_last;
		logic pipe_busy;
		logic out_hold;
	} sts_t;

	// base(priority) times weight, zero weight meaning the default
	function automatic logic [BWW-1:0] base_weight(input logic [1:0] prio,
			input logic [6:0] wt);
		logic [BWW-1:0] w;
		w = (wt == 7'd0) ? BWW'(WEIGHT_DEF) : BWW'(wt);
		case (prio)
			PRIO_HIGH: base_weight = w << 2;
			PRIO_MID:  base_weight = w << 1;
			default:   base_weight = w;
		endcase
	endfunction

endpackage

// ----- hdl/usch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module usch_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
	input  logic [W-1:0]                         wr_data,
	input  logic                                 rd_en,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
	output logic [W-1:0]                         rd_data
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/usch_dp.sv -----
// Scheduler datapath: entry RAM, VM depth table, scoring pipeline, result register.
// Depends on usch_pkg and usch_ram.
module usch_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  usch_pkg::cmd_t  cmd,
	output usch_pkg::sts_t  sts,
	input  usch_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output usch_pkg::rsp_t  out_data
);
	import usch_pkg::*;

	req_t             item_q;
	logic [QCW-1:0]   total_q;
	logic [VCW-1:0]   used_q;
	logic [31:0]      vm_id_q [VM_SLOTS];
	logic [DW-1:0]    vm_dep_q [VM_SLOTS];
	logic [31:0]      last_vm_q;
	logic [31:0]      switch_q;
	logic [1:0]       res_status_q;
	logic [QIW-1:0]   scan_cnt_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             full;
	logic             empty;
	logic [QIW-1:0]   last_idx;

	// RAM port signals
	logic             ram_we;
	logic [QIW-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic             ram_re;
	logic [QIW-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           enq_ent;
	entry_t           e1;

	// scoring pipeline
	logic             v_s1, v_s2, v_s3, v_s4;
	logic [QIW-1:0]   idx_s1, idx_s2, idx_s3, idx_s4;
	entry_t           ent_s2, ent_s3, ent_s4;
	logic [BWW-1:0]   bw_s2;
	logic [DW-1:0]    dep_s2;
	logic [31:0]      el_s2;
	logic [PW-1:0]    p_s3;
	logic [EW-1:0]    e_s3;
	logic [SCORE_W-1:0] sc_s4;
	logic             hit1;
	logic [VIW-1:0]   k1;
	logic [DW-1:0]    dep1;
	logic [DW:0]      dp10;
	logic [MW-1:0]    prod;

	// best candidate
	logic             have_q;
	logic [SCORE_W-1:0] best_sc_q;
	logic [QIW-1:0]   best_idx_q;
	entry_t           best_q;

	// VM table update
	logic [31:0]      lk_vm;
	logic             hit2;
	logic [VIW-1:0]   k2;
	logic             can_reg;
	logic [VIW-1:0]   reg_k;
	logic             vt_we;
	logic             vt_new;
	logic [DW-1:0]    vt_dep;
	logic             deq_ok;

	assign full     = total_q >= QCW'(QUEUE_SLOTS);
	assign empty    = total_q == '0;
	assign last_idx = QIW'(total_q - QCW'(1));

	// status to the controller
	always_comb begin
		sts.go_scan   = (item_q.req_type == REQ_DEQ) && !empty;
		sts.scan_last = scan_cnt_q == last_idx;
		sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
		sts.out_hold  = out_valid_q && out_stall;
	end

	// entry write data on enqueue, weight clamped
	always_comb begin
		enq_ent.vm      = item_q.vm_id;
		enq_ent.request = item_q.req_tag;
		enq_ent.prio    = item_q.priority_req;
		enq_ent.weight  = (item_q.weight > WEIGHT_MAX) ? WEIGHT_MAX : item_q.weight;
		enq_ent.stamp   = item_q.now_ms;
	end

	assign ram_we    = (cmd.exec && (item_q.req_type == REQ_ENQ) && !full) || cmd.mv_wr;
	assign ram_waddr = cmd.mv_wr ? best_idx_q : QIW'(total_q);
	assign ram_wdata = cmd.mv_wr ? ram_rdata : ENTRY_W'(enq_ent);
	assign ram_re    = cmd.scan || cmd.mv_rd;
	assign ram_raddr = cmd.mv_rd ? last_idx : scan_cnt_q;

	usch_ram #(.W(ENTRY_W), .D(QUEUE_SLOTS)) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign e1 = entry_t'(ram_rdata);

	// stage 1 depth lookup for the entry just read
	always_comb begin
		hit1 = 1'b0;
		k1   = '0;
		for (int i = VM_SLOTS - 1; i >= 0; i--) begin
			if ((VCW'(i) < used_q) && (vm_id_q[i] == e1.vm)) begin
				hit1 = 1'b1;
				k1   = VIW'(i);
			end
		end
		dep1 = hit1 ? vm_dep_q[k1] : '0;
	end

	assign dp10 = {1'b0, dep_s2} + (DW+1)'(10);
	assign prod = MW'(p_s3) * MW'(e_s3);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q;
		idx_s2 <= idx_s1;
		ent_s2 <= e1;
		bw_s2  <= base_weight(e1.prio, e1.weight);
		dep_s2 <= dep1;
		el_s2  <= item_q.now_ms - e1.stamp;
		idx_s3 <= idx_s2;
		ent_s3 <= ent_s2;
		p_s3   <= PW'(bw_s2) * PW'(dp10);
		e_s3   <= {1'b0, el_s2} + EW'(10000);
		idx_s4 <= idx_s3;
		ent_s4 <= ent_s3;
		sc_s4  <= (prod > MW'(SCORE_MAX)) ? SCORE_MAX : prod[SCORE_W-1:0];
	end

	// best score tracking, strict greater keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.exec) begin
			have_q <= 1'b0;
		end else if (v_s4) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (!have_q || (sc_s4 > best_sc_q))) begin
			best_sc_q  <= sc_s4;
			best_idx_q <= idx_s4;
			best_q     <= ent_s4;
		end
	end

	// VM lookup for enqueue, completion and removal
	assign lk_vm = cmd.mv_wr ? best_q.vm : item_q.vm_id;

	always_comb begin
		hit2 = 1'b0;
		k2   = '0;
		for (int i = VM_SLOTS - 1; i >= 0; i--) begin
			if ((VCW'(i) < used_q) && (vm_id_q[i] == lk_vm)) begin
				hit2 = 1'b1;
				k2   = VIW'(i);
			end
		end
	end

	assign can_reg = hit2 || (used_q < VCW'(VM_SLOTS));
	assign reg_k   = hit2 ? k2 : VIW'(used_q);

	always_comb begin
		vt_we  = 1'b0;
		vt_dep = '0;
		if (cmd.exec && (item_q.req_type == REQ_ENQ) && !full && can_reg) begin
			vt_we  = 1'b1;
			vt_dep = hit2 ? (vm_dep_q[k2] + DW'(1)) : DW'(1);
		end else if (cmd.exec && (item_q.req_type == REQ_CPL) && can_reg) begin
			vt_we  = !hit2;
		end else if (cmd.mv_wr && can_reg) begin
			vt_we  = 1'b1;
			if (hit2 && (vm_dep_q[k2] != '0)) begin
				vt_dep = vm_dep_q[k2] - DW'(1);
			end
		end
	end
	assign vt_new = vt_we && !hit2;

	always_ff @(posedge clk) begin
		if (vt_we) begin
			vm_dep_q[reg_k] <= vt_dep;
		end
		if (vt_new) begin
			vm_id_q[reg_k] <= lk_vm;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			used_q       <= '0;
			last_vm_q    <= '0;
			switch_q     <= '0;
			res_status_q <= ST_OK;
			scan_cnt_q   <= '0;
		end else begin
			if (vt_new) begin
				used_q <= used_q + VCW'(1);
			end
			if (cmd.exec) begin
				scan_cnt_q <= '0;
				case (item_q.req_type)
					REQ_ENQ: begin
						if (full) begin
							res_status_q <= ST_FULL;
						end else begin
							res_status_q <= ST_OK;
							total_q      <= total_q + QCW'(1);
						end
					end
					REQ_DEQ: res_status_q <= empty ? ST_EMPTY : ST_OK;
					default: res_status_q <= ST_OK;
				endcase
			end
			if (cmd.scan) begin
				scan_cnt_q <= scan_cnt_q + QIW'(1);
			end
			if (cmd.mv_wr) begin
				total_q   <= total_q - QCW'(1);
				last_vm_q <= best_q.vm;
				if ((last_vm_q != '0) && (last_vm_q != best_q.vm)) begin
					switch_q <= switch_q + 32'd1;
				end
			end
		end
	end

	// result register
	assign deq_ok = (item_q.req_type == REQ_DEQ) && (res_status_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.status       <= res_status_q;
			out_q.out_vm_id    <= deq_ok ? best_q.vm : 32'd0;
			out_q.out_req_tag  <= deq_ok ? best_q.request : 32'd0;
			out_q.out_priority <= deq_ok ? best_q.prio : 2'd0;
			out_q.out_weight   <= deq_ok ? best_q.weight : 7'd0;
			out_q.out_score    <= deq_ok ? best_sc_q : '0;
			out_q.queue_count  <= QC_W'(total_q);
			out_q.switch_count <= switch_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hdl/usch_ctrl.sv -----
// Scheduler controller: sequences accept, execute, scan, drain, move and result steps.
// Depends on usch_pkg.
module usch_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  usch_pkg::sts_t sts,
	output usch_pkg::cmd_t cmd
);
	import usch_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_MVRD  = 3'd4;
	localparam logic [2:0] S_MVWR  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.go_scan ? S_SCAN : S_FIN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_MVRD;
				end
			end
			S_MVRD: begin
				cmd.mv_rd = 1'b1;
				state_d   = S_MVWR;
			end
			S_MVWR: begin
				cmd.mv_wr = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_hold) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/urgency_weighted_request_scheduler_top.sv -----
// Top level of the urgency-weighted request scheduler.
// Depends on usch_pkg, usch_ctrl, usch_dp and assert_macros.svh.
//
//   channel | handshake            | beat
//   --------+----------------------+-----------------
//   in      | in_valid / in_stall  | usch_pkg::req_t
//   out     | out_valid / out_stall| usch_pkg::rsp_t
//
// Enqueue, completion, no-op and empty dequeue: accept, execute, then the result is
// registered in the final step; the next beat is taken only once the controller is idle.
// Dequeue of N entries: N scan steps through a four-stage scoring pipeline, a drain,
// then the last entry moves into the chosen slot and the result is registered.
// Reset clears the counts; entry and VM stores need no clearing.
// The input stays stalled while an item is worked on; a stalled result holds the
// controller at its final step.
module urgency_weighted_request_scheduler_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  usch_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output usch_pkg::rsp_t out_data
);
	import usch_pkg::*;
	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// assertion helpers
	logic [QC_W-1:0] out_cnt;
	logic            out_full_st;
	logic            out_empty_st;

	usch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	usch_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign out_cnt      = out_data.queue_count;
	assign out_full_st  = out_valid && (out_data.status == ST_FULL);
	assign out_empty_st = out_valid && (out_data.status == ST_EMPTY);

	// an accepted beat keeps the input stalled while it is worked on
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
	// count never exceeds capacity
	`ASSERT_IMPL(a_count_bound, out_valid, out_cnt <= QC_W'(QUEUE_SLOTS), "count above capacity")
	// full status only with a full queue
	`ASSERT_IMPL(a_full_count, out_full_st, out_cnt == QC_W'(QUEUE_SLOTS), "full with room left")
	// empty status only with an empty queue
	`ASSERT_IMPL(a_empty_count, out_empty_st, out_cnt == '0, "empty status with entries held")

endmodule
